@@ hdl/tnpdb_pkg.sv @@
// Package for the three-nearest-point distance blend block.
// Payload structs, register indexes and constants; no dependencies.
package tnpdb_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned SqW          = 36;
  localparam int unsigned DistW        = 18;
  localparam int unsigned BlendW       = 24;
  localparam logic [DistW-1:0] EmptyDist = '1;
  localparam logic [SqW-1:0]   EmptySq   = 36'd68718952449; // 262143^2

  typedef enum logic [1:0] {
    REG_W1     = 2'd0,
    REG_W2     = 2'd1,
    REG_W3     = 2'd2,
    REG_ACTIVE = 2'd3
  } reg_idx_e;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [7:0]         point_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] blend_value;
    logic [17:0]        nearest_distance;
  } out_item_t;

endpackage

@@ hdl/three_nearest_point_distance_blend_top.sv @@
// Top level of the three-nearest-point distance blend block.
// Depends on tnpdb_pkg. Point table memory, scan pipeline, isqrt and blend.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | tnpdb_pkg::in_item_t
//  out     | output    | out_valid_o/stall_i| tnpdb_pkg::out_item_t
//  cfg     | input     | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A load writes one table entry. A query scans N entries (N = active points
// clamped to the table size, one table read per cycle through a 4-stage
// pipe), then takes the bit-pair square root of the three nearest squared
// distances in turn, then forms product, sum and saturation before the beat
// is offered. Reset clears control state, sets W1 to 4096 and W2, W3 and
// active to 0; the table is undefined until loaded.
// in_stall_o is high whenever a query is in work or its result is not taken.
module three_nearest_point_distance_blend_top #(
  parameter int unsigned MAX_POINTS = tnpdb_pkg::MaxPointsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tnpdb_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tnpdb_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import tnpdb_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SQRT, ST_MUL, ST_SUM, ST_OUT
  } state_e;

  logic signed [15:0] w1_q, w2_q, w3_q;
  logic [8:0]         active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= 16'sd4096; w2_q <= '0; w3_q <= '0; active_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_W1:     w1_q <= cfg_data_i;
        REG_W2:     w2_q <= cfg_data_i;
        REG_W3:     w3_q <= cfg_data_i;
        REG_ACTIVE: active_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // point table
  logic [47:0] mem_q [MAX_POINTS];
  logic [47:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  state_e state_q;
  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mem_we = in_acc && (in_data_i.mode == MODE_LOAD)
                  && ({24'd0, in_data_i.point_index} < 32'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (mem_we)
      mem_q[AW'(in_data_i.point_index)] <=
        {in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
    rd_q <= mem_q[rd_addr];
  end

  // scan pipe: issue -> read -> diffs/squares -> sum -> insert
  logic [CW-1:0] cnt_q, limit_q;
  logic signed [15:0] qx_q, qy_q, qz_q;
  logic v1_q, v2_q, v3_q;
  logic [33:0] px_q, py_q, pz_q;
  logic [SqW-1:0] sq_q, s1_q, s2_q, s3_q;
  logic [CW-1:0] limit_d;

  assign rd_addr = cnt_q[AW-1:0];
  assign limit_d = ({23'd0, active_q} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                         : CW'(active_q);

  logic signed [16:0] dx, dy, dz;
  assign dx = 17'(qx_q) - 17'($signed(rd_q[47:32]));
  assign dy = 17'(qy_q) - 17'($signed(rd_q[31:16]));
  assign dz = 17'(qz_q) - 17'($signed(rd_q[15:0]));

  // square root unit
  logic [1:0]     sidx_q;
  logic [4:0]     step_q;
  logic [SqW-1:0] rem_q;
  logic [DistW:0] root_q;
  logic [DistW-1:0] d1_q, d2_q, d3_q;
  logic [SqW+1:0] trial;
  logic [SqW-1:0] rem_sh;
  assign rem_sh = rem_q;
  logic [SqW-1:0] src;
  always_comb begin
    case (sidx_q)
      2'd0:    src = s1_q;
      2'd1:    src = s2_q;
      default: src = s3_q;
    endcase
  end
  // restoring bit-pair: acc = rem<<2 | next pair; trial = root<<2 | 1
  logic [SqW+1:0] acc;
  logic [1:0]     pair;
  assign pair  = src[6'(2*(17 - step_q)) +: 2];
  assign acc   = {rem_sh, pair};
  assign trial = {{(SqW-DistW-1){1'b0}}, root_q, 2'b01};

  logic signed [35:0] p1_q, p2_q, p3_q;
  logic signed [37:0] sum_q;
  logic signed [25:0] sh;
  assign sh = 26'(sum_q >>> 12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_o <= 1'b0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      cnt_q <= '0; limit_q <= '0; sidx_q <= '0; step_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.mode == MODE_QUERY) begin
            qx_q <= in_data_i.coord_x; qy_q <= in_data_i.coord_y;
            qz_q <= in_data_i.coord_z;
            s1_q <= EmptySq; s2_q <= EmptySq; s3_q <= EmptySq;
            cnt_q <= '0; limit_q <= limit_d;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          v1_q <= (cnt_q < limit_q);
          if (cnt_q < limit_q) cnt_q <= cnt_q + 1'b1;
          v2_q <= v1_q;
          if (v1_q) begin
            px_q <= 34'(dx * dx); py_q <= 34'(dy * dy); pz_q <= 34'(dz * dz);
          end
          v3_q <= v2_q;
          if (v2_q) sq_q <= SqW'(px_q) + SqW'(py_q) + SqW'(pz_q);
          if (v3_q) begin
            if (sq_q < s1_q) begin
              s3_q <= s2_q; s2_q <= s1_q; s1_q <= sq_q;
            end else if (sq_q < s2_q) begin
              s3_q <= s2_q; s2_q <= sq_q;
            end else if (sq_q < s3_q) s3_q <= sq_q;
          end
          if (!(cnt_q < limit_q) && !v1_q && !v2_q && !v3_q) begin
            state_q <= ST_SQRT; sidx_q <= '0; step_q <= '0;
            rem_q <= '0; root_q <= '0;
          end
        end
        ST_SQRT: begin
          if (acc >= trial) begin
            rem_q  <= SqW'(acc - trial);
            root_q <= {root_q[DistW-1:0], 1'b1};
          end else begin
            rem_q  <= SqW'(acc);
            root_q <= {root_q[DistW-1:0], 1'b0};
          end
          if (step_q == 5'd17) begin
            case (sidx_q)
              2'd0:    d1_q <= (acc >= trial) ? {root_q[16:0], 1'b1} : {root_q[16:0], 1'b0};
              2'd1:    d2_q <= (acc >= trial) ? {root_q[16:0], 1'b1} : {root_q[16:0], 1'b0};
              default: d3_q <= (acc >= trial) ? {root_q[16:0], 1'b1} : {root_q[16:0], 1'b0};
            endcase
            step_q <= '0; rem_q <= '0; root_q <= '0;
            if (sidx_q == 2'd2) state_q <= ST_MUL;
            sidx_q <= sidx_q + 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_MUL: begin
          p1_q <= 36'(w1_q * $signed({1'b0, d1_q}));
          p2_q <= 36'(w2_q * $signed({1'b0, d2_q}));
          p3_q <= 36'(w3_q * $signed({1'b0, d3_q}));
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_q <= 38'(p1_q) + 38'(p2_q) + 38'(p3_q);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            out_data_o.nearest_distance <= d1_q;
            if (sh > 26'sd8388607)       out_data_o.blend_value <= 24'sh7FFFFF;
            else if (sh < -26'sd8388608) out_data_o.blend_value <= 24'sh800000;
            else                         out_data_o.blend_value <= 24'(sh);
          end else if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
